### design/accumulator_integer_calculator_assert.svh
// Assertion macros used by the port-level checker.
`ifndef ACCUMULATOR_INTEGER_CALCULATOR_ASSERT_SVH
`define ACCUMULATOR_INTEGER_CALCULATOR_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define AIC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aic check failed");

// Next-cycle implication.
`define AIC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aic check failed");

// Condition that must never hold.
`define AIC_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("aic check failed");

`endif

### design/aic_pkg.sv
// Types and codes shared by the accumulator calculator modules.
`default_nettype none
package aic_pkg;

    localparam int OP_WIDTH  = 4;
    localparam int ERR_WIDTH = 3;

    localparam logic [OP_WIDTH-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL   = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV   = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_SQR   = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_POW   = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_ROOT  = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_FACT  = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_CLEAR = 4'd8;

    localparam logic [ERR_WIDTH-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_DIV0       = 3'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_NEGFACT    = 3'd2;
    localparam logic [ERR_WIDTH-1:0] ERR_NEGROOT    = 3'd3;
    localparam logic [ERR_WIDTH-1:0] ERR_ZERONEGPOW = 3'd4;
    localparam logic [ERR_WIDTH-1:0] ERR_BADOP      = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_RUN, S_PCHK, S_PM1, S_PM2, S_COMMIT, S_OUT
    } t_state;

    // how a decoded request is carried out
    typedef enum logic [2:0] {
        K_SIMPLE, K_MUL, K_DIV, K_ROOT, K_FACT, K_POW
    } t_kind;

    typedef enum logic [1:0] {U_MUL, U_DIV, U_ROOT, U_FACT} t_unit;

    // multiplier operand/destination select
    typedef enum logic [1:0] {MS_XY, MS_RB, MS_BB} t_msel;

    typedef struct packed {
        logic  load;
        logic  start;
        t_unit unit;
        t_msel msel;
        logic  step;
        logic  store;
        logic  commit;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  iter_done;
        logic  e_zero;
        logic  e_lsb;
    } t_dp_sts;

endpackage
`default_nettype wire

### design/aic_ctrl.sv
// Sequencing state machine for the accumulator calculator.
`default_nettype none
module aic_ctrl
    import aic_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    K_MUL: begin
                        o_cmd.start = 1'b1;
                        o_cmd.unit  = U_MUL;
                        o_cmd.msel  = MS_XY;
                        n_state     = S_RUN;
                    end
                    K_DIV: begin
                        o_cmd.start = 1'b1;
                        o_cmd.unit  = U_DIV;
                        n_state     = S_RUN;
                    end
                    K_ROOT: begin
                        o_cmd.start = 1'b1;
                        o_cmd.unit  = U_ROOT;
                        n_state     = S_RUN;
                    end
                    K_FACT: begin
                        o_cmd.start = 1'b1;
                        o_cmd.unit  = U_FACT;
                        n_state     = S_RUN;
                    end
                    K_POW:   n_state = S_PCHK;
                    default: n_state = S_COMMIT;
                endcase
            end
            S_RUN: begin
                if (i_sts.iter_done) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_COMMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            // square-and-multiply, one exponent bit per pass
            S_PCHK: begin
                if (i_sts.e_zero) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.start = 1'b1;
                    o_cmd.unit  = U_MUL;
                    if (i_sts.e_lsb) begin
                        o_cmd.msel = MS_RB;
                        n_state    = S_PM1;
                    end else begin
                        o_cmd.msel = MS_BB;
                        n_state    = S_PM2;
                    end
                end
            end
            S_PM1: begin
                if (i_sts.iter_done) begin
                    o_cmd.store = 1'b1;
                    o_cmd.start = 1'b1;
                    o_cmd.unit  = U_MUL;
                    o_cmd.msel  = MS_BB;
                    n_state     = S_PM2;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_PM2: begin
                if (i_sts.iter_done) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_PCHK;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### design/aic_dp.sv
// Datapath: accumulator, request decode and the shared iterative unit.
`default_nettype none
module aic_dp
    import aic_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic        [OP_WIDTH-1:0]   i_operation,
    input  wire logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  wire logic signed [DATA_WIDTH-1:0] i_operand_b,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_sts                           o_sts,
    output logic signed      [DATA_WIDTH-1:0] o_result_value,
    output logic             [ERR_WIDTH-1:0]  o_error_code
);

    localparam int W  = DATA_WIDTH;
    localparam int RW = 2 * ((W + 1) / 2);
    localparam int CW = $clog2(2 * W + 1);
    localparam logic [CW-1:0] MUL_STEPS  = CW'(W);
    localparam logic [CW-1:0] ROOT_STEPS = CW'(RW / 2);
    localparam logic [CW-1:0] FACT_FIRST = CW'(2);
    localparam logic [W-1:0]  ONE        = W'(1);
    localparam logic [W-1:0]  FACT_LIMIT = W'(2 * W);
    localparam logic [W-1:0]  ROOT_BIT   = ONE << (RW - 2);

    logic [W-1:0]         r_acc;
    logic                 r_chain;
    logic [OP_WIDTH-1:0]  r_op;
    t_kind                r_kind;
    logic [ERR_WIDTH-1:0] r_err;
    logic [W-1:0]         r_res;
    logic [W-1:0]         r_x;    // left operand, base during power
    logic [W-1:0]         r_y;    // right operand, exponent during power
    t_unit                r_unit;
    t_msel                r_msel;
    logic                 r_neg;
    logic [CW-1:0]        r_cnt;
    logic [W-1:0]         r_ta, r_tb, r_tc;
    logic [W-1:0]         r_out_val;
    logic [ERR_WIDTH-1:0] r_out_err;

    logic [W-1:0]         x_in, y_in;
    t_kind                n_kind;
    logic [ERR_WIDTH-1:0] n_err;
    logic [W-1:0]         n_res, n_y;
    logic [W-1:0]         mul_a, mul_b, mag_x, mag_y;
    logic [W:0]           rem_sh, trial, rsum;
    logic [W+CW-1:0]      fact_prod;

    assign x_in = r_chain ? r_acc : i_operand_a;
    assign y_in = i_operand_b;

    // decode: simple results come out here, iterative ones pick a kind
    always_comb begin
        n_kind = K_SIMPLE;
        n_err  = ERR_OK;
        n_res  = '0;
        n_y    = y_in;
        case (i_operation)
            OP_ADD: n_res = x_in + y_in;
            OP_SUB: n_res = x_in - y_in;
            OP_MUL: n_kind = K_MUL;
            OP_DIV: begin
                if (y_in == '0) n_err = ERR_DIV0;
                else            n_kind = K_DIV;
            end
            OP_SQR: begin
                n_kind = K_MUL;
                n_y    = x_in;
            end
            OP_POW: begin
                if (y_in[W-1]) begin
                    if (x_in == '0)      n_err = ERR_ZERONEGPOW;
                    else if (x_in == ONE) n_res = ONE;
                    else if (x_in == '1) n_res = y_in[0] ? '1 : ONE;
                    else                 n_res = '0;
                end else begin
                    n_kind = K_POW;
                    n_res  = ONE;
                end
            end
            OP_ROOT: begin
                if (x_in[W-1]) n_err = ERR_NEGROOT;
                else           n_kind = K_ROOT;
            end
            OP_FACT: begin
                if (x_in[W-1])              n_err = ERR_NEGFACT;
                else if (x_in >= FACT_LIMIT) n_res = '0;
                else                        n_kind = K_FACT;
            end
            OP_CLEAR: n_res = '0;
            default:  n_err = ERR_BADOP;
        endcase
    end

    always_comb begin
        case (i_cmd.msel)
            MS_RB: begin
                mul_a = r_res;
                mul_b = r_x;
            end
            MS_BB: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_y;
            end
        endcase
    end

    assign mag_x     = r_x[W-1] ? (~r_x + ONE) : r_x;
    assign mag_y     = r_y[W-1] ? (~r_y + ONE) : r_y;
    assign rem_sh    = {r_tc, r_ta[W-1]};
    assign trial     = rem_sh - {1'b0, r_tb};
    assign rsum      = {1'b0, r_tc} + {1'b0, r_tb};
    assign fact_prod = r_res * r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_chain <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op   <= i_operation;
                r_kind <= n_kind;
                r_err  <= n_err;
                r_res  <= n_res;
                r_x    <= x_in;
                r_y    <= n_y;
            end
            if (i_cmd.start) begin
                r_unit <= i_cmd.unit;
                r_msel <= i_cmd.msel;
                case (i_cmd.unit)
                    U_MUL: begin
                        r_ta  <= mul_a;
                        r_tb  <= mul_b;
                        r_tc  <= '0;
                        r_cnt <= MUL_STEPS;
                    end
                    U_DIV: begin
                        r_ta  <= mag_x;
                        r_tb  <= mag_y;
                        r_tc  <= '0;
                        r_cnt <= MUL_STEPS;
                        r_neg <= r_x[W-1] ^ r_y[W-1];
                    end
                    U_ROOT: begin
                        r_ta  <= r_x;
                        r_tb  <= ROOT_BIT;
                        r_tc  <= '0;
                        r_cnt <= ROOT_STEPS;
                    end
                    default: begin
                        r_res <= ONE;
                        r_cnt <= FACT_FIRST;
                    end
                endcase
            end
            if (i_cmd.step) begin
                case (r_unit)
                    U_MUL: begin
                        if (r_tb[0]) r_tc <= r_tc + r_ta;
                        r_ta  <= r_ta << 1;
                        r_tb  <= r_tb >> 1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                    // restoring division, quotient bits shift into r_ta
                    U_DIV: begin
                        if (!trial[W]) begin
                            r_tc <= trial[W-1:0];
                            r_ta <= {r_ta[W-2:0], 1'b1};
                        end else begin
                            r_tc <= rem_sh[W-1:0];
                            r_ta <= {r_ta[W-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end
                    // digit-by-digit root: r_ta remainder, r_tb bit, r_tc root
                    U_ROOT: begin
                        if ({1'b0, r_ta} >= rsum) begin
                            r_ta <= r_ta - rsum[W-1:0];
                            r_tc <= (r_tc >> 1) + r_tb;
                        end else begin
                            r_tc <= r_tc >> 1;
                        end
                        r_tb  <= r_tb >> 2;
                        r_cnt <= r_cnt - 1'b1;
                    end
                    default: begin
                        r_res <= fact_prod[W-1:0];
                        r_cnt <= r_cnt + 1'b1;
                    end
                endcase
            end
            if (i_cmd.store) begin
                case (r_unit)
                    U_MUL: begin
                        if (r_msel == MS_BB) begin
                            r_x <= r_tc;
                            r_y <= r_y >> 1;
                        end else begin
                            r_res <= r_tc;
                        end
                    end
                    U_DIV:   r_res <= r_neg ? (~r_ta + ONE) : r_ta;
                    U_ROOT:  r_res <= r_tc;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_out_err <= r_err;
                if (r_op == OP_CLEAR) begin
                    r_acc     <= '0;
                    r_chain   <= 1'b0;
                    r_out_val <= '0;
                end else if (r_err == ERR_OK) begin
                    r_acc     <= r_res;
                    r_chain   <= 1'b1;
                    r_out_val <= r_res;
                end else begin
                    r_out_val <= r_acc;
                end
            end
        end
    end

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.iter_done = (r_unit == U_FACT) ? (r_cnt > r_x[CW-1:0]) : (r_cnt == '0);
        o_sts.e_zero    = (r_y == '0);
        o_sts.e_lsb     = r_y[0];
    end

    assign o_result_value = r_out_val;
    assign o_error_code   = r_out_err;

endmodule
`default_nettype wire

### design/accumulator_integer_calculator.sv
// Top level of the accumulator integer calculator.
// One request at a time: o_ready is high only while the block is idle, and the
// result then stays on o_valid until taken. Add, subtract, clear, errors and the
// closed-form power cases are worked out in decode; multiply and square take one
// bit per cycle through the shift-add multiplier, divide one quotient bit per
// cycle (restoring divider), root one root bit per cycle, and factorial one
// small multiply per cycle. Power runs the shift-add multiplier once or twice
// per exponent bit.
`default_nettype none
module accumulator_integer_calculator
    import aic_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic        [OP_WIDTH-1:0]   i_operation,
    input  wire logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  wire logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed      [DATA_WIDTH-1:0] o_result_value,
    output logic             [ERR_WIDTH-1:0]  o_error_code
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    aic_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    aic_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (i_operation),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_value (o_result_value),
        .o_error_code   (o_error_code)
    );

endmodule
`default_nettype wire

### design/aic_chk.sv
// Port-level checks for the accumulator calculator, bound to the top level.
`default_nettype none
`include "accumulator_integer_calculator_assert.svh"
module aic_chk
    import aic_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_ready,
    input wire logic                 o_valid,
    input wire logic                 i_ready,
    input wire logic [ERR_WIDTH-1:0] o_error_code
);

    `AIC_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid)
    `AIC_ASSERT_NEVER(a_one_at_a_time, o_valid && o_ready)
    `AIC_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    `AIC_ASSERT_NXT(a_idle_after_result, o_valid && i_ready, o_ready)
    `AIC_ASSERT_IMP(a_err_range, o_valid, o_error_code <= ERR_BADOP)

endmodule

bind accumulator_integer_calculator aic_chk u_aic_chk (.*);
`default_nettype wire

### tb/sv/aic_checker.sv
// Checker: watches both channels, predicts each result and compares.
`timescale 1ns / 100ps
module aic_checker
    import aic_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic        [OP_WIDTH-1:0]   i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic signed [DATA_WIDTH-1:0] o_result_value,
    input  logic        [ERR_WIDTH-1:0]  o_error_code,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef struct packed {
        t_word                value;
        logic [ERR_WIDTH-1:0] code;
    } t_answer;

    t_word   acc_model;
    logic    chain_model;
    t_answer answer_q[$];

    function automatic t_word int_sqrt(t_word v);
        t_word res;
        res = '0;
        for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
            t_word trial;
            trial = res | (t_word'(1) << i);
            if ({{DATA_WIDTH{1'b0}}, trial} * trial <= {{DATA_WIDTH{1'b0}}, v})
                res = trial;
        end
        return res;
    endfunction

    // computes the answer and updates the model state
    function automatic t_answer calc_answer(logic [OP_WIDTH-1:0] op, t_word a, t_word b);
        t_word x, r, base, e, mx, my, q;
        logic [ERR_WIDTH-1:0] err;
        x = chain_model ? acc_model : a;
        r = '0;
        err = ERR_OK;
        case (op)
            OP_ADD: r = x + b;
            OP_SUB: r = x - b;
            OP_MUL: r = x * b;
            OP_SQR: r = x * x;
            OP_DIV: begin
                if (b == '0) err = ERR_DIV0;
                else begin
                    mx = x[DATA_WIDTH-1] ? -x : x;
                    my = b[DATA_WIDTH-1] ? -b : b;
                    q = mx / my;
                    r = (x[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? -q : q;
                end
            end
            OP_POW: begin
                if (b[DATA_WIDTH-1]) begin
                    if (x == '0) err = ERR_ZERONEGPOW;
                    else if (x == t_word'(1)) r = 1;
                    else if (x == '1) r = b[0] ? '1 : t_word'(1);
                    else r = '0;
                end else begin
                    r = 1;
                    base = x;
                    e = b;
                    while (e != '0) begin
                        if (e[0]) r = r * base;
                        base = base * base;
                        e = e >> 1;
                    end
                end
            end
            OP_ROOT: begin
                if (x[DATA_WIDTH-1]) err = ERR_NEGROOT;
                else r = int_sqrt(x);
            end
            OP_FACT: begin
                if (x[DATA_WIDTH-1]) err = ERR_NEGFACT;
                else if (x >= t_word'(2 * DATA_WIDTH)) r = '0;
                else begin
                    r = 1;
                    for (t_word k = 2; k <= x; k++) r = r * k;
                end
            end
            OP_CLEAR: begin
                acc_model = '0;
                chain_model = 1'b0;
                return '{value: '0, code: ERR_OK};
            end
            default: err = ERR_BADOP;
        endcase
        if (err == ERR_OK) begin
            acc_model = r;
            chain_model = 1'b1;
        end
        return '{value: acc_model, code: err};
    endfunction

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        t_answer want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            acc_model = '0;
            chain_model = 1'b0;
            answer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_valid && o_ready)
                answer_q.push_back(calc_answer(i_operation, i_operand_a, i_operand_b));
            if (o_valid && i_ready) begin
                if (answer_q.size() == 0) begin
                    $error("result with no request pending");
                    errs++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_result_value !== want.value) begin
                        $error("result_value exp %h got %h", want.value, o_result_value);
                        errs++;
                    end
                    if (o_error_code !== want.code) begin
                        $error("error_code exp %0d got %0d", want.code, o_error_code);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

### tb/sv/testbench.sv
// Testbench top: stimulus, idling, watchdog and verdict for the calculator.
`timescale 1ns / 100ps
module testbench;
    import aic_pkg::*;

    localparam int DW = 32;
    localparam int WATCH_LIMIT = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [OP_WIDTH-1:0]  i_operation = '0;
    logic signed [DW-1:0] i_operand_a = '0;
    logic signed [DW-1:0] i_operand_b = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [DW-1:0] o_result_value;
    logic [ERR_WIDTH-1:0] o_error_code;
    int                   fail_count;
    int                   pending;
    logic                 hold_off = 1'b0;
    int                   idle_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    accumulator_integer_calculator #(.DATA_WIDTH(DW)) u_top (.*);

    aic_checker #(.DATA_WIDTH(DW)) u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation, .i_operand_a,
        .i_operand_b, .o_valid, .i_ready, .o_result_value, .o_error_code,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // random word, biased toward small and edge values
    function automatic logic [DW-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(3) - 1;
            3, 4: return $urandom_range(40) - 8;
            default: return $urandom();
        endcase
    endfunction

    // exponents mostly small to keep power fast
    function automatic logic [DW-1:0] pick_exp();
        if ($urandom_range(9) == 0) return $urandom();
        return $urandom_range(20) - 4;
    endfunction

    // valid stays high after the accept; the caller drops it before any gap
    task automatic send_req(logic [OP_WIDTH-1:0] op, logic [DW-1:0] a, logic [DW-1:0] b);
        i_valid <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_gap(logic [OP_WIDTH-1:0] op, logic [DW-1:0] a, logic [DW-1:0] b);
        int g;
        g = gap_len();
        send_req(op, a, b);
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // receiver side
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
            end else begin
                g = gap_len();
                if (g == 0) i_ready <= 1'b1;
                else begin
                    i_ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        logic [OP_WIDTH-1:0] op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: edges, every op, every error case
        send_gap(OP_ROOT, 32'h7fff_ffff, 0);
        send_gap(OP_CLEAR, 0, 0);
        send_gap(OP_ADD, 32'h7fff_ffff, 1);
        send_gap(OP_SUB, 0, 32'hffff_ffff);
        send_gap(OP_MUL, 0, 32'h8000_0000);
        send_gap(OP_CLEAR, 0, 0);
        send_gap(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_gap(OP_DIV, 0, 0);
        send_gap(OP_CLEAR, 0, 0);
        send_gap(OP_ROOT, 32'h8000_0000, 0);
        send_gap(OP_FACT, 32'hffff_ffff, 0);
        send_gap(OP_FACT, 0, 0);
        send_gap(OP_POW, 0, 0);
        send_gap(OP_SQR, 0, 0);
        send_gap(OP_CLEAR, 0, 0);
        send_gap(OP_POW, 0, 32'hffff_fffd);
        send_gap(OP_POW, 32'hffff_ffff, 32'hffff_fffd);
        send_gap(OP_POW, 32'hffff_ffff, 32'hffff_fffe);
        send_gap(OP_CLEAR, 0, 0);
        send_gap(OP_POW, 3, 32'h7fff_ffff);
        send_gap(OP_CLEAR, 0, 0);
        send_gap(OP_FACT, 63, 0);
        send_gap(OP_CLEAR, 0, 0);
        send_gap(OP_FACT, 64, 0);
        send_gap(4'hf, 0, 0);

        // long receiver stall while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_req(OP_ADD, $urandom(), $urandom());
        join

        for (int n = 0; n < 900; n++) begin
            if (n == 450) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            case ($urandom_range(19))
                0: op = OP_CLEAR;
                1: op = 4'(OP_CLEAR + $urandom_range(7));
                2, 3: op = OP_POW;
                default: op = 4'($urandom_range(7));
            endcase
            send_gap(op, pick_word(), (op == OP_POW) ? pick_exp() : pick_word());
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/aic_pkg.sv
design/aic_ctrl.sv
design/aic_dp.sv
design/accumulator_integer_calculator.sv
design/aic_chk.sv
tb/sv/aic_checker.sv
tb/sv/testbench.sv
